/* hw/rtl/lpkt_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe key table package
// Shared widths, codes and control structures of the key table.
// ----------------------------------------------------------------------------
package lpkt_pkg;

	localparam int KEY_W          = 32;
	localparam int REQ_W          = 2;
	localparam int STATUS_W       = 3;
	localparam int SLOT_W         = 10;
	localparam int TABLE_SIZE_DEF = 1024;

	// Request codes; the fourth code is undefined and answers not found.
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STS_FOUND     = 3'd0,
		STS_INSERTED  = 3'd1,
		STS_NOT_FOUND = 3'd2,
		STS_FULL      = 3'd3,
		STS_CLEARED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_HASH,
		S_FETCH,
		S_PROBE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    hash_go;
		logic    fetch;
		logic    step;
		logic    write;
		logic    sweep;
		logic    respond;
		logic    use_slot;
		status_t code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic key_zero;
		logic home_ready;
		logic hit;
		logic empty;
		logic room;
		logic sweep_last;
	} sts_t;

endpackage

/* hw/rtl/lpkt_mod.sv */
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces a key modulo the table size: a mask for a power-of-two size,
// otherwise a reciprocal multiplication and one correcting subtraction,
// registered through the quotient, first remainder and home registers.
// ----------------------------------------------------------------------------
module lpkt_mod #(
	parameter int TABLE_SIZE = lpkt_pkg::TABLE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [lpkt_pkg::KEY_W-1:0]       key,
	output logic                             ready,
	output logic [$clog2(TABLE_SIZE)-1:0]    home
);
	import lpkt_pkg::*;

	localparam int  IDX_W   = $clog2(TABLE_SIZE);
	localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	logic             done_q;
	logic [IDX_W-1:0] rem_q;

	assign ready = done_q;
	assign home  = rem_q;

	if (IS_POW2) begin : g_mask
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else if (go) begin
				done_q <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (go) begin
				rem_q <= key[IDX_W-1:0];
			end
		end
	end else begin : g_recip
		// The scaled reciprocal gives a quotient at most one short, so the
		// first remainder lies below twice the table size.
		localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));
		localparam logic [KEY_W-1:0] MODULUS = KEY_W'(TABLE_SIZE);
		localparam logic [IDX_W:0]   MOD_EXT = (IDX_W+1)'(TABLE_SIZE);

		logic [2*KEY_W-1:0] prod;
		logic [KEY_W-1:0]   est;
		logic [IDX_W:0]     reduced;
		logic [KEY_W-1:0]   key_s1;
		logic [KEY_W-1:0]   quot_s1;
		logic [IDX_W:0]     rem_s2;
		logic               vld_s1;
		logic               vld_s2;

		assign prod    = (2*KEY_W)'(key) * (2*KEY_W)'(RECIP);
		assign est     = key_s1 - quot_s1 * MODULUS;
		assign reduced = (rem_s2 >= MOD_EXT) ? rem_s2 - MOD_EXT : rem_s2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				done_q <= 1'b0;
			end else begin
				vld_s1 <= go;
				vld_s2 <= vld_s1;
				if (go) begin
					done_q <= 1'b0;
				end else if (vld_s2) begin
					done_q <= 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (go) begin
				key_s1  <= key;
				quot_s1 <= prod[2*KEY_W-1:KEY_W];
			end
			if (vld_s1) begin
				rem_s2 <= est[IDX_W:0];
			end
			if (vld_s2) begin
				rem_q <= reduced[IDX_W-1:0];
			end
		end
	end

endmodule

/* hw/rtl/lpkt_dp.sv */
// ----------------------------------------------------------------------------
// Key table datapath
// Key memory, probe index, fill count, clearing sweep and result registers.
// ----------------------------------------------------------------------------
module lpkt_dp #(
	parameter int TABLE_SIZE = lpkt_pkg::TABLE_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lpkt_pkg::KEY_W-1:0]        key,
	input  lpkt_pkg::cmd_t                    cmd,
	output lpkt_pkg::sts_t                    sts,
	output logic                              done,
	output logic [lpkt_pkg::STATUS_W-1:0]     status,
	output logic [lpkt_pkg::SLOT_W-1:0]       slot
);
	import lpkt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

	logic [KEY_W-1:0]    mem_q [TABLE_SIZE];
	logic [KEY_W-1:0]    rdata_s1;
	logic [KEY_W-1:0]    key_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_next;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [KEY_W-1:0]    wr_data;
	logic                wr_en;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    count_q;
	logic [IDX_W-1:0]    home;
	logic                home_ready;
	logic [EXT_W-1:0]    idx_ext;
	logic                done_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_q;

	lpkt_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.hash_go),
		.key    (key),
		.ready  (home_ready),
		.home   (home)
	);

	assign idx_next = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign rd_addr  = cmd.fetch ? home : (cmd.step ? idx_next : idx_q);
	assign wr_en    = cmd.sweep | cmd.write;
	assign wr_addr  = cmd.sweep ? clr_q : idx_q;
	assign wr_data  = cmd.sweep ? '0 : key_q;
	assign idx_ext  = EXT_W'(idx_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
		end
		if (cmd.fetch || cmd.step) begin
			idx_q <= rd_addr;
		end
		if (cmd.respond) begin
			status_q <= cmd.code;
			slot_q   <= cmd.use_slot ? idx_ext[SLOT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.sweep) begin
				clr_q   <= (clr_q == LAST) ? '0 : clr_q + 1'b1;
				count_q <= '0;
			end else if (cmd.write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		sts            = '0;
		sts.key_zero   = (key == '0);
		sts.home_ready = home_ready;
		sts.hit        = (rdata_s1 == key_q);
		sts.empty      = (rdata_s1 == '0);
		// One slot always stays free, so the count never passes the last index.
		sts.room       = (count_q < LAST);
		sts.sweep_last = (clr_q == LAST);
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

/* hw/rtl/lpkt_ctrl.sv */
// ----------------------------------------------------------------------------
// Key table controller
// Sequences the clearing sweep, the home slot reduction and the probe walk.
// ----------------------------------------------------------------------------
module lpkt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpkt_pkg::REQ_W-1:0]    req_type,
	input  lpkt_pkg::sts_t                sts,
	output lpkt_pkg::cmd_t                cmd,
	output logic                          busy
);
	import lpkt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   ins_q;
	logic   clr_resp_q;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q      <= 1'b0;
			clr_resp_q <= 1'b0;
		end else begin
			if (accept) begin
				ins_q      <= (req_type == REQ_INSERT);
				clr_resp_q <= (req_type == REQ_CLEAR);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = STS_NOT_FOUND;
		case (state_q)
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d     = S_IDLE;
					cmd.respond = clr_resp_q;
					cmd.code    = STS_CLEARED;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_CLEAR) begin
						state_d = S_SWEEP;
					end else if ((req_type == REQ_FIND || req_type == REQ_INSERT)
					             && !sts.key_zero) begin
						cmd.load    = 1'b1;
						cmd.hash_go = 1'b1;
						state_d     = S_HASH;
					end else begin
						cmd.respond = 1'b1;
					end
				end
			end
			S_HASH: begin
				if (sts.home_ready) begin
					cmd.fetch = 1'b1;
					state_d   = S_PROBE;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_PROBE;
			end
			S_PROBE: begin
				if (sts.hit) begin
					cmd.respond  = 1'b1;
					cmd.use_slot = 1'b1;
					cmd.code     = STS_FOUND;
					state_d      = S_IDLE;
				end else if (sts.empty) begin
					cmd.respond = 1'b1;
					state_d     = S_IDLE;
					if (ins_q && sts.room) begin
						cmd.write    = 1'b1;
						cmd.use_slot = 1'b1;
						cmd.code     = STS_INSERTED;
					end else if (ins_q) begin
						cmd.code = STS_FULL;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/linear_probe_key_table.sv */
// ----------------------------------------------------------------------------
// Linear probe key table
// A find or insert with a nonzero key, once accepted, first forms the home slot
// and reads it from memory (through the reciprocal reduction registers when
// the table size is not a power of two), then probes one slot a cycle through
// the single read port, and the result is shown in the cycle after. Zero keys
// and the undefined request answer in the next cycle; a clear sweeps one slot
// a cycle through the whole table. Busy falls as the result is shown, so the
// next item can be taken in that cycle.
// After reset the same sweep runs with busy high and no result. Each result is
// shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module linear_probe_key_table #(
	parameter int TABLE_SIZE = lpkt_pkg::TABLE_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpkt_pkg::REQ_W-1:0]        req_type,
	input  logic [lpkt_pkg::KEY_W-1:0]        key,
	output logic                              busy,
	output logic                              done,
	output logic [lpkt_pkg::STATUS_W-1:0]     status,
	output logic [lpkt_pkg::SLOT_W-1:0]       slot
);
	import lpkt_pkg::*;

	// The controller issues one command word a cycle and the datapath answers
	// with a status word; nothing else passes between them.
	cmd_t cmd;
	sts_t sts;

	// The controller owns the request sequencing: it accepts an item when idle,
	// waits for the home slot, walks the probe one slot a cycle and decides the
	// answer from the match, empty-slot and room flags.
	lpkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// The datapath holds the key memory, the probe index, the fill count, the
	// sweep counter and the result registers. A result register parts the
	// answer from the controller, so a new item may be accepted in the cycle
	// in which the previous answer is on the ports.
	lpkt_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.status (status),
		.slot   (slot)
	);

endmodule

/* bench/linear_probe_key_table_test.sv */
// ----------------------------------------------------------------------------
// Linear probe key table testbench
// Drives find, insert and clear requests into the key table through the
// start/busy handshake and checks every status and slot against a table model
// kept here. The run opens with a short table of hand-picked requests, then
// random traffic on clustered and recurring keys, then a fill of the table
// until it refuses new keys, and ends with more random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_key_table_test;

	import lpkt_pkg::*;

	// The table size is the block's default, so the slot field is the full index.
	localparam int unsigned SLOTS = TABLE_SIZE_DEF;

	// The fourth request code has no meaning and must answer not found.
	localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

	localparam int NUM_DIRECTED = 24;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [KEY_W-1:0]  key;
		logic              typed;
		status_t           code;
		logic [SLOT_W-1:0] slot;
	} directed_row_t;

	typedef struct {
		status_t           code;
		logic [SLOT_W-1:0] slot;
	} answer_t;

	// Hand-picked opening requests. Rows with typed set carry an answer that
	// is plain from the request alone; the rest are answered by the model.
	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{REQ_FIND,   32'h0000_0000, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_FIND,   32'hFFFF_FFFF, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_INSERT, 32'h0000_0000, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_UNDEF,  32'h1234_5678, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_INSERT, 32'd5,         1'b1, STS_INSERTED,  10'd5},
		'{REQ_INSERT, 32'd5,         1'b1, STS_FOUND,     10'd5},
		'{REQ_INSERT, 32'd1029,      1'b1, STS_INSERTED,  10'd6},
		'{REQ_FIND,   32'd1029,      1'b1, STS_FOUND,     10'd6},
		'{REQ_FIND,   32'd2053,      1'b0, STS_FOUND,     10'd0},
		'{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, STS_INSERTED,  10'd1023},
		'{REQ_INSERT, 32'h0000_03FF, 1'b0, STS_FOUND,     10'd0},
		'{REQ_INSERT, 32'h8000_03FF, 1'b0, STS_FOUND,     10'd0},
		'{REQ_FIND,   32'h0000_03FF, 1'b0, STS_FOUND,     10'd0},
		'{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, STS_FOUND,     10'd0},
		'{REQ_INSERT, 32'h5555_5555, 1'b0, STS_FOUND,     10'd0},
		'{REQ_FIND,   32'h5555_5555, 1'b0, STS_FOUND,     10'd0},
		'{REQ_UNDEF,  32'h0000_0000, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_FIND,   32'h8000_03FF, 1'b0, STS_FOUND,     10'd0},
		'{REQ_CLEAR,  32'hDEAD_BEEF, 1'b1, STS_CLEARED,   10'd0},
		'{REQ_FIND,   32'd5,         1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_FIND,   32'hFFFF_FFFF, 1'b1, STS_NOT_FOUND, 10'd0},
		'{REQ_INSERT, 32'd1024,      1'b1, STS_INSERTED,  10'd0},
		'{REQ_INSERT, 32'd1,         1'b1, STS_INSERTED,  10'd1},
		'{REQ_CLEAR,  32'h0000_0000, 1'b1, STS_CLEARED,   10'd0}
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic [REQ_W-1:0]  req_type = '0;
	logic [KEY_W-1:0]  key      = '0;
	logic              busy;
	logic              done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	// The model's own copy of the table and its fill count.
	logic [KEY_W-1:0] model_slots [SLOTS];
	int unsigned      keys_held;

	answer_t          expected_answers [$];
	logic [KEY_W-1:0] recent_keys [$];
	int unsigned      failure_count = 0;
	bit               steady_run    = 1'b0;

	linear_probe_key_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.key      (key),
		.busy     (busy),
		.done     (done),
		.status   (status),
		.slot     (slot)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Only the first ten failures are described; the rest are just counted.
	task automatic note_failure(input string what);
		failure_count++;
		if (failure_count <= 10) begin
			$display("%0t: %s", $realtime, what);
		end
	endtask

	// Works out the answer to one request and applies it to the model table.
	// A probe runs from the home slot, key modulo the table size, one slot at a
	// time with wraparound, and stops on the key or on the first empty slot.
	task automatic lookup_in_table(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k,
			output status_t code, output logic [SLOT_W-1:0] where);
		int unsigned idx;
		int unsigned n;
		bit          hit;
		bit          empty_seen;
		code  = STS_NOT_FOUND;
		where = '0;
		if (req == REQ_CLEAR) begin
			foreach (model_slots[i]) begin
				model_slots[i] = '0;
			end
			keys_held = 0;
			code      = STS_CLEARED;
		end else if ((req == REQ_FIND || req == REQ_INSERT) && k != '0) begin
			idx        = k % SLOTS;
			hit        = 1'b0;
			empty_seen = 1'b0;
			for (n = 0; n < SLOTS && !hit && !empty_seen; n++) begin
				if (model_slots[idx] == '0) begin
					empty_seen = 1'b1;
				end else if (model_slots[idx] == k) begin
					hit = 1'b1;
				end else begin
					idx = (idx + 1) % SLOTS;
				end
			end
			if (hit) begin
				code  = STS_FOUND;
				where = idx[SLOT_W-1:0];
			end else if (req == REQ_INSERT) begin
				// The last free slot is never taken, so a probe always ends.
				if (!empty_seen || keys_held + 1 >= SLOTS) begin
					code = STS_FULL;
				end else begin
					model_slots[idx] = k;
					keys_held++;
					code  = STS_INSERTED;
					where = idx[SLOT_W-1:0];
				end
			end
		end
	endtask

	// Presents one request after a random pause, waits for the block to take
	// it, then records the answer it owes. Start stays high between items
	// that follow with no pause, so it is never lowered and raised in one step.
	task automatic offer_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k,
			input bit typed, input status_t typed_code, input logic [SLOT_W-1:0] typed_slot);
		int unsigned       gap;
		answer_t           owed;
		status_t           code;
		logic [SLOT_W-1:0] where;
		gap = steady_run ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 39) == 0) begin
			steady_run = !steady_run;
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= req;
		key      <= k;
		do @(posedge clk); while (busy);
		lookup_in_table(req, k, code, where);
		owed.code = typed ? typed_code : code;
		owed.slot = typed ? typed_slot : where;
		expected_answers.push_back(owed);
		if (k != '0) begin
			recent_keys.push_back(k);
			if (recent_keys.size() > 64) begin
				void'(recent_keys.pop_front());
			end
		end
	endtask

	// Random traffic. Keys are drawn so that probes collide: many share a
	// handful of home slots (some near the top, to force wraparound), many
	// come back from recent requests so that finds hit, and a few are zero.
	task automatic run_mixed(input int unsigned count);
		logic [REQ_W-1:0] req;
		logic [KEY_W-1:0] k;
		int unsigned      pick;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				req = REQ_CLEAR;
			end else if (pick < 5) begin
				req = REQ_UNDEF;
			end else if (pick < 40) begin
				req = REQ_FIND;
			end else begin
				req = REQ_INSERT;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				k = '0;
			end else if (pick < 45 && recent_keys.size() != 0) begin
				k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			end else if (pick < 60) begin
				k = ($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 40);
			end else if (pick < 75) begin
				k = ($urandom() & 32'hFFFF_FC00) | $urandom_range(1000, 1023);
			end else begin
				k = $urandom();
			end
			offer_request(req, k, 1'b0, STS_FOUND, '0);
		end
	endtask

	// Each strobed result is compared with the oldest answer still owed.
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d slot %0d", status, slot));
			end else begin
				want = expected_answers.pop_front();
				if (status !== want.code || slot !== want.slot) begin
					note_failure($sformatf("status %0d slot %0d, expected status %0d slot %0d",
						status, slot, want.code, want.slot));
				end
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] fill_base;
		int unsigned      fill_next;
		foreach (model_slots[i]) begin
			model_slots[i] = '0;
		end
		keys_held = 0;

		// Reset is released at a clock edge; the block then sweeps its table
		// with busy high, which the first handshake simply waits out.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening table: zero keys, the undefined code, a duplicate insert,
		// a collision, wraparound from the last slot to slot 0 and clears.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].slot);
		end

		run_mixed(180);

		// Fill the table from empty until only the one slot that is never
		// taken is left. Runs of consecutive keys keep most probes short; the
		// random keys between them land in and around those runs.
		offer_request(REQ_CLEAR, $urandom(), 1'b0, STS_FOUND, '0);
		fill_base = $urandom_range(1, 32'hF000_0000);
		fill_next = 0;
		while (keys_held < SLOTS - 1) begin
			if ($urandom_range(0, 9) == 0) begin
				offer_request(REQ_FIND, $urandom(), 1'b0, STS_FOUND, '0);
			end else if ($urandom_range(0, 3) == 0) begin
				offer_request(REQ_INSERT, $urandom_range(1, 32'hFFFF_FFFF), 1'b0,
					STS_FOUND, '0);
			end else begin
				offer_request(REQ_INSERT, fill_base + fill_next, 1'b0, STS_FOUND, '0);
				fill_next++;
			end
		end

		// With the table full, new keys must be refused, keys already held
		// must still be found, and a miss probes nearly the whole table.
		for (int i = 0; i < 30; i++) begin
			case ($urandom_range(0, 4))
				0: offer_request(REQ_INSERT, $urandom(), 1'b0, STS_FOUND, '0);
				1: offer_request(REQ_INSERT, fill_base + $urandom_range(0, fill_next - 1),
					1'b0, STS_FOUND, '0);
				2: offer_request(REQ_FIND, $urandom(), 1'b0, STS_FOUND, '0);
				3: offer_request(REQ_FIND, fill_base + $urandom_range(0, fill_next - 1),
					1'b0, STS_FOUND, '0);
				default: offer_request($urandom_range(0, 1) ? REQ_UNDEF : REQ_INSERT, '0,
					1'b0, STS_FOUND, '0);
			endcase
		end

		offer_request(REQ_CLEAR, $urandom(), 1'b0, STS_FOUND, '0);
		run_mixed(180);
		start <= 1'b0;

		// Every request answers, so once nothing is owed only a short tail is
		// watched for stray strobes.
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		if (expected_answers.size() != 0) begin
			note_failure($sformatf("%0d answers never arrived", expected_answers.size()));
		end
		if (failure_count == 0) begin
			$display("linear_probe_key_table_test OK");
		end else begin
			$display("linear_probe_key_table_test NOT OK");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every request probing the whole
	// table after the longest pause, plus the sweep after reset.
	initial begin : watchdog
		#(150_000_000);
		$display("linear_probe_key_table_test NOT OK");
		$finish;
	end

endmodule

/* linear_probe_key_table.f */
hw/rtl/lpkt_pkg.sv
hw/rtl/lpkt_mod.sv
hw/rtl/lpkt_dp.sv
hw/rtl/lpkt_ctrl.sv
hw/rtl/linear_probe_key_table.sv
bench/linear_probe_key_table_test.sv
